// ===== rtl/core/renc_pkg.sv =====
// Shared types and constants of the rotary encoder and button event unit.
package renc_pkg;

    // Request codes carried in req_type.
    typedef enum logic [1:0] {
        REQ_RESYNC    = 2'd0,
        REQ_UPDATE    = 2'd1,
        REQ_POP       = 2'd2,
        REQ_RESET_POS = 2'd3
    } req_t;

    // Event kinds as stored in the queue and returned on a pop.
    localparam logic [1:0] EV_CW          = 2'd0;
    localparam logic [1:0] EV_CCW         = 2'd1;
    localparam logic [1:0] EV_SHORT_PRESS = 2'd2;
    localparam logic [1:0] EV_LONG_PRESS  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DETENT_COUNTS   = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE_TIME   = 2'd1;
    localparam logic [1:0] CFG_LONG_PRESS_TIME = 2'd2;

    localparam int unsigned CFG_DATA_W = 24;

    // Register values after reset.
    localparam logic [3:0]  DETENT_RESET     = 4'd4;
    localparam logic [19:0] DEBOUNCE_RESET   = 20'd20000;
    localparam logic [23:0] LONG_PRESS_RESET = 24'd500000;

    // Largest usable detent count.
    localparam logic [3:0] DETENT_MAX = 4'd8;

    // Count change per A/B transition, indexed by {previous AB, new AB}.
    localparam logic signed [1:0] TRANS_DELTA [16] = '{
        2'sd0, -2'sd1,  2'sd1,  2'sd0,
        2'sd1,  2'sd0,  2'sd0, -2'sd1,
       -2'sd1,  2'sd0,  2'sd0,  2'sd1,
        2'sd0,  2'sd1, -2'sd1,  2'sd0
    };

    // Detent step decided by the quadrature decoder.
    typedef struct packed {
        logic cw;
        logic ccw;
    } quad_step_t;

    // Button events decided by the debouncer.
    typedef struct packed {
        logic short_press;
        logic long_press;
    } btn_event_t;

    // Push requests into the event queue, rotation first.
    typedef struct packed {
        logic       rot_push;
        logic [1:0] rot_kind;
        logic       btn_push;
        logic [1:0] btn_kind;
    } evt_push_t;

    // One queue entry.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] pos;
    } evt_entry_t;

endpackage

// ===== rtl/core/renc_if.sv =====
// Request and result channel interfaces of the rotary encoder event unit.
interface renc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic        pin_a;
    logic        pin_b;
    logic        button_level;
    logic [63:0] now_us;

    modport source (output valid, req_type, pin_a, pin_b, button_level, now_us,
                    input ready);
    modport sink (input valid, req_type, pin_a, pin_b, button_level, now_us,
                  output ready);
endinterface

interface renc_evt_if;
    logic               valid;
    logic               ready;
    logic               event_valid;
    logic [1:0]         event_kind;
    logic signed [31:0] event_position;
    logic signed [31:0] position;
    logic               button_pressed;
    logic signed [3:0]  partial_count;
    logic [3:0]         pending_events;

    modport source (output valid, event_valid, event_kind, event_position, position,
                    button_pressed, partial_count, pending_events,
                    input ready);
    modport sink (input valid, event_valid, event_kind, event_position, position,
                  button_pressed, partial_count, pending_events,
                  output ready);
endinterface

// ===== rtl/core/renc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module renc_ram #(
    parameter int unsigned WIDTH = 34,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/renc_quad.sv =====
// Quadrature decoder: transition table, partial count and detent position.
module renc_quad import renc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  req_t               req_kind,
    input  logic               pin_a,
    input  logic               pin_b,
    input  logic [3:0]         detent_counts,
    output quad_step_t         step,
    output logic signed [31:0] position_next,
    output logic signed [3:0]  partial_next
);

    logic [1:0]         last_ab_reg;
    logic [1:0]         last_ab_next;
    logic signed [3:0]  partial_reg;
    logic signed [31:0] position_reg;

    logic [1:0]         ab;
    logic               moved;
    logic signed [1:0]  delta;
    logic signed [4:0]  sum;
    logic signed [4:0]  lim;

    // Clamp the detent count to one through eight.
    always_comb
    begin
        if (detent_counts == 4'd0)
        begin
            lim = 5'sd1;
        end
        else if (detent_counts > DETENT_MAX)
        begin
            lim = signed'({1'b0, DETENT_MAX});
        end
        else
        begin
            lim = signed'({1'b0, detent_counts});
        end
    end

    assign ab    = {pin_a, pin_b};
    assign moved = (ab != last_ab_reg);
    assign delta = TRANS_DELTA[{last_ab_reg, ab}];
    assign sum   = {partial_reg[3], partial_reg} + {{3{delta[1]}}, delta};

    // Next decoder state for the request.
    always_comb
    begin
        last_ab_next  = last_ab_reg;
        partial_next  = partial_reg;
        position_next = position_reg;
        step          = '0;
        unique case (req_kind)
            REQ_RESYNC:
            begin
                last_ab_next  = ab;
                partial_next  = 4'sd0;
                position_next = 32'sd0;
            end
            REQ_UPDATE:
            begin
                if (moved)
                begin
                    last_ab_next = ab;
                    if (sum >= lim)
                    begin
                        partial_next  = 4'sd0;
                        position_next = position_reg + 32'sd1;
                        step.cw       = 1'b1;
                    end
                    else if (sum <= -lim)
                    begin
                        partial_next  = 4'sd0;
                        position_next = position_reg - 32'sd1;
                        step.ccw      = 1'b1;
                    end
                    else
                    begin
                        partial_next = sum[3:0];
                    end
                end
            end
            REQ_RESET_POS:
            begin
                partial_next  = 4'sd0;
                position_next = 32'sd0;
            end
            REQ_POP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Decoder state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_ab_reg  <= 2'b00;
            partial_reg  <= 4'sd0;
            position_reg <= 32'sd0;
        end
        else if (accept)
        begin
            last_ab_reg  <= last_ab_next;
            partial_reg  <= partial_next;
            position_reg <= position_next;
        end
    end

`ifndef SYNTHESIS
    // The partial count never reaches a full negative nibble.
    a_partial_range: assert property (@(posedge clk) disable iff (!rst_n)
        partial_reg != -4'sd8)
        else $error("partial count out of range");
`endif

endmodule

// ===== rtl/core/renc_button.sv =====
// Button debouncer with short and long press detection.
module renc_button import renc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  req_t        req_kind,
    input  logic        button_level,
    input  logic [63:0] now_us,
    input  logic [19:0] debounce_time,
    input  logic [23:0] long_press_time,
    output btn_event_t  btn_event,
    output logic        pressed_next
);

    logic        stable_reg;
    logic        cand_reg;
    logic        long_reg;
    logic [63:0] ctime_reg;
    logic [63:0] ptime_reg;
    logic        cand_next;
    logic        long_next;
    logic [63:0] ctime_next;
    logic [63:0] ptime_next;

    logic        level_down;
    logic        changed;
    logic        deb_ok;
    logic        take_level;
    logic        just_pressed;
    logic        long_mid;
    logic        long_ok;
    logic [63:0] cand_age;
    logic [63:0] press_age;

    assign level_down = !button_level;
    assign changed    = (level_down != cand_reg);
    assign cand_age   = now_us - ctime_reg;
    assign press_age  = now_us - ptime_reg;

    // Debounce and press timing; both age compares run in parallel.
    always_comb
    begin
        deb_ok = changed ? (debounce_time == 20'd0)
                         : (cand_age >= {44'd0, debounce_time});
        take_level   = (level_down != stable_reg) && deb_ok;
        just_pressed = take_level && level_down;
        long_mid     = just_pressed ? 1'b0 : long_reg;
        long_ok      = just_pressed ? (long_press_time == 24'd0)
                                    : (press_age >= {40'd0, long_press_time});
    end

    // Next button state for the request.
    always_comb
    begin
        pressed_next = stable_reg;
        cand_next    = cand_reg;
        long_next    = long_reg;
        ctime_next   = ctime_reg;
        ptime_next   = ptime_reg;
        btn_event    = '0;
        unique case (req_kind)
            REQ_RESYNC:
            begin
                pressed_next = level_down;
                cand_next    = level_down;
                long_next    = 1'b0;
                ctime_next   = now_us;
                ptime_next   = now_us;
            end
            REQ_UPDATE:
            begin
                cand_next    = level_down;
                ctime_next   = changed ? now_us : ctime_reg;
                pressed_next = take_level ? level_down : stable_reg;
                ptime_next   = just_pressed ? now_us : ptime_reg;
                btn_event.short_press = take_level && !level_down && !long_reg;
                btn_event.long_press  = pressed_next && !long_mid && long_ok;
                long_next    = long_mid || btn_event.long_press;
            end
            REQ_POP, REQ_RESET_POS:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Button state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b0;
            cand_reg   <= 1'b0;
            long_reg   <= 1'b0;
            ctime_reg  <= 64'd0;
            ptime_reg  <= 64'd0;
        end
        else if (accept)
        begin
            stable_reg <= pressed_next;
            cand_reg   <= cand_next;
            long_reg   <= long_next;
            ctime_reg  <= ctime_next;
            ptime_reg  <= ptime_next;
        end
    end

endmodule

// ===== rtl/core/renc_evq.sv =====
// Event queue: slot pointers, event memory and deferred second write.
module renc_evq import renc_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  req_t               req_kind,
    input  evt_push_t          push,
    input  logic signed [31:0] position,
    output logic               hit,
    output logic               busy,
    output logic [3:0]         pending_next,
    output evt_entry_t         rd_entry
);

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = AW + 1;

    logic [AW-1:0] rd_reg;
    logic [AW-1:0] wr_reg;
    logic [AW-1:0] rd_next;
    logic [AW-1:0] wr_next;
    logic [AW-1:0] wr_mid;
    logic          p0_ok;
    logic          p1_ok;

    logic          defer_valid_reg;
    logic [AW-1:0] defer_addr_reg;
    evt_entry_t    defer_data_reg;
    logic          defer_load;

    logic          we;
    logic [AW-1:0] waddr;
    evt_entry_t    wdata;
    logic          re;
    logic [CW-1:0] count;
    logic [CW+3:0] count_wide;
    logic [$bits(evt_entry_t)-1:0] ram_rdata;

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
        return (s == AW'(QUEUE_DEPTH - 1)) ? '0 : s + AW'(1);
    endfunction

    // Pointer moves for the request; one slot is always left free.
    always_comb
    begin
        rd_next = rd_reg;
        wr_next = wr_reg;
        wr_mid  = wr_reg;
        p0_ok   = 1'b0;
        p1_ok   = 1'b0;
        hit     = 1'b0;
        unique case (req_kind)
            REQ_RESYNC:
            begin
                rd_next = '0;
                wr_next = '0;
            end
            REQ_UPDATE:
            begin
                p0_ok   = push.rot_push && (slot_inc(wr_reg) != rd_reg);
                wr_mid  = p0_ok ? slot_inc(wr_reg) : wr_reg;
                p1_ok   = push.btn_push && (slot_inc(wr_mid) != rd_reg);
                wr_next = p1_ok ? slot_inc(wr_mid) : wr_mid;
            end
            REQ_POP:
            begin
                if (rd_reg != wr_reg)
                begin
                    hit     = 1'b1;
                    rd_next = slot_inc(rd_reg);
                end
            end
            REQ_RESET_POS:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Memory write selection: a deferred write goes first, a second push waits.
    always_comb
    begin
        we         = 1'b0;
        waddr      = wr_reg;
        wdata      = '{kind: push.rot_kind, pos: $unsigned(position)};
        defer_load = 1'b0;
        if (defer_valid_reg)
        begin
            we    = 1'b1;
            waddr = defer_addr_reg;
            wdata = defer_data_reg;
        end
        else if (accept && p0_ok)
        begin
            we         = 1'b1;
            defer_load = p1_ok;
        end
        else if (accept && p1_ok)
        begin
            we    = 1'b1;
            wdata = '{kind: push.btn_kind, pos: $unsigned(position)};
        end
    end

    assign re   = accept && hit;
    assign busy = defer_valid_reg;

    // Fill level after the request, saturated to the field width.
    always_comb
    begin
        if (wr_next >= rd_next)
        begin
            count = {1'b0, wr_next} - {1'b0, rd_next};
        end
        else
        begin
            count = {1'b0, wr_next} + CW'(QUEUE_DEPTH) - {1'b0, rd_next};
        end
        count_wide   = {4'd0, count};
        pending_next = (count_wide > (CW + 4)'(15)) ? 4'd15 : count_wide[3:0];
    end

    // Pointer and deferred write registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg          <= '0;
            wr_reg          <= '0;
            defer_valid_reg <= 1'b0;
        end
        else
        begin
            defer_valid_reg <= defer_load;
            if (accept)
            begin
                rd_reg <= rd_next;
                wr_reg <= wr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (defer_load)
        begin
            defer_addr_reg <= wr_mid;
            defer_data_reg <= '{kind: push.btn_kind, pos: $unsigned(position)};
        end
    end

    renc_ram #(
        .WIDTH ($bits(evt_entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (rd_reg),
        .rdata (ram_rdata)
    );

    assign rd_entry = evt_entry_t'(ram_rdata);

`ifndef SYNTHESIS
    // A pop never reads the slot that is being written in the same cycle.
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        re && we |-> waddr != rd_reg)
        else $error("event read and write hit the same slot");
`endif

endmodule

// ===== rtl/core/rotary_encoder_button_event_unit.sv =====
// Top level of the rotary encoder and push button event unit.
// Takes one request per clock while the result channel is not backed up:
// resync, update sample, pop event or reset position, and returns one result
// per request through the issue stage, then the output register. The other
// exception to the one-per-clock rate is an update that queues both a detent
// event and a button event: the event memory has a single write port, so the
// second write goes into the following cycle and the request channel is held
// off meanwhile. Events live in a QUEUE_DEPTH-entry memory that holds
// up to QUEUE_DEPTH-1 events; new events are dropped when it is full. No
// clearing pass is needed after reset. Configuration writes are not gated
// by the unit, so they should be made only while no request is in flight.
module rotary_encoder_button_event_unit import renc_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    renc_req_if.sink              req,
    renc_evt_if.source            evt
);

    typedef struct packed {
        logic               hit;
        logic signed [31:0] position;
        logic               pressed;
        logic signed [3:0]  partial;
        logic [3:0]         pending;
    } issue_t;

    typedef struct packed {
        logic               hit;
        logic [1:0]         kind;
        logic signed [31:0] epos;
        logic signed [31:0] position;
        logic               pressed;
        logic signed [3:0]  partial;
        logic [3:0]         pending;
    } result_t;

    logic [3:0]  detent_reg;
    logic [19:0] debounce_reg;
    logic [23:0] long_press_reg;

    logic               accept;
    req_t               req_kind;
    quad_step_t         step;
    btn_event_t         btn_event;
    evt_push_t          push;
    logic signed [31:0] position_next;
    logic signed [3:0]  partial_next;
    logic               pressed_next;
    logic               hit;
    logic               evq_busy;
    logic [3:0]         pending_next;
    evt_entry_t         rd_entry;

    logic               s1_valid_reg;
    issue_t             s1_reg;
    logic               s1_move;
    logic               out_valid_reg;
    result_t            out_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detent_reg     <= DETENT_RESET;
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DETENT_COUNTS:   detent_reg     <= cfg_data[3:0];
                CFG_DEBOUNCE_TIME:   debounce_reg   <= cfg_data[19:0];
                CFG_LONG_PRESS_TIME: long_press_reg <= cfg_data[23:0];
                default:
                begin
                end
            endcase
        end
    end

    // Request handshake: the issue stage moves on whenever the output frees up.
    assign s1_move   = s1_valid_reg && (!out_valid_reg || evt.ready);
    assign req.ready = !evq_busy && (!s1_valid_reg || !out_valid_reg || evt.ready);
    assign accept    = req.valid && req.ready;
    assign req_kind  = req_t'(req.req_type);

    renc_quad u_quad (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .req_kind      (req_kind),
        .pin_a         (req.pin_a),
        .pin_b         (req.pin_b),
        .detent_counts (detent_reg),
        .step          (step),
        .position_next (position_next),
        .partial_next  (partial_next)
    );

    renc_button u_button (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .req_kind        (req_kind),
        .button_level    (req.button_level),
        .now_us          (req.now_us),
        .debounce_time   (debounce_reg),
        .long_press_time (long_press_reg),
        .btn_event       (btn_event),
        .pressed_next    (pressed_next)
    );

    // Rotation event first, then at most one button event.
    always_comb
    begin
        push.rot_push = step.cw || step.ccw;
        push.rot_kind = step.cw ? EV_CW : EV_CCW;
        push.btn_push = btn_event.short_press || btn_event.long_press;
        push.btn_kind = btn_event.long_press ? EV_LONG_PRESS : EV_SHORT_PRESS;
    end

    renc_evq #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_evq (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .req_kind     (req_kind),
        .push         (push),
        .position     (position_next),
        .hit          (hit),
        .busy         (evq_busy),
        .pending_next (pending_next),
        .rd_entry     (rd_entry)
    );

    // Issue stage: status after the request, waiting for the memory read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= '{hit: hit, position: position_next, pressed: pressed_next,
                        partial: partial_next, pending: pending_next};
        end
    end

    // Output register; event fields read as zero when nothing was popped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (evt.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_reg.hit      <= s1_reg.hit;
            out_reg.kind     <= s1_reg.hit ? rd_entry.kind : EV_CW;
            out_reg.epos     <= s1_reg.hit ? signed'(rd_entry.pos) : 32'sd0;
            out_reg.position <= s1_reg.position;
            out_reg.pressed  <= s1_reg.pressed;
            out_reg.partial  <= s1_reg.partial;
            out_reg.pending  <= s1_reg.pending;
        end
    end

    assign evt.valid          = out_valid_reg;
    assign evt.event_valid    = out_reg.hit;
    assign evt.event_kind     = out_reg.kind;
    assign evt.event_position = out_reg.epos;
    assign evt.position       = out_reg.position;
    assign evt.button_pressed = out_reg.pressed;
    assign evt.partial_count  = out_reg.partial;
    assign evt.pending_events = out_reg.pending;

`ifndef SYNTHESIS
    // A pending second memory write holds off new requests.
    a_busy_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        evq_busy |-> !req.ready)
        else $error("request taken while a queue write is pending");

    // A result without a popped event carries zero event fields.
    a_empty_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        evt.valid && !evt.event_valid |-> evt.event_kind == EV_CW &&
            evt.event_position == 32'sd0)
        else $error("event fields not cleared on an empty result");

    // An issue stage that saw a queued entry always yields a popped event at the output.
    a_hit_from_issue: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && s1_reg.hit |=> evt.valid && evt.event_valid)
        else $error("popped event lost between issue and output");
`endif

endmodule

// ===== verif/tb_rotary_encoder_button_event_unit.sv =====
// Self-checking testbench of the rotary encoder and push button event unit.
module tb_rotary_encoder_button_event_unit
    import renc_pkg::*;
();

    // Register values after reset, register index that maps to nothing, limits.
    localparam logic [3:0]  DETENT_AT_RESET     = 4'd4;
    localparam logic [19:0] DEBOUNCE_AT_RESET   = 20'd20000;
    localparam logic [23:0] LONG_PRESS_AT_RESET = 24'd500000;
    localparam logic [1:0]  CFG_UNUSED_INDEX    = 2'd3;
    localparam int          DETENT_CEILING      = 8;
    localparam int          QUIET_LIMIT         = 2000;
    localparam int          PHASE_ITEMS         = 130;
    localparam int          N_DIRECTED          = 27;
    localparam int          N_PHASES            = 6;

    // Gray order of the A/B pair for clockwise rotation (A is bit 1).
    localparam logic [1:0] QUAD_ORDER [4] = '{2'b00, 2'b10, 2'b11, 2'b01};

    typedef struct {
        req_t        op;
        logic        a;
        logic        b;
        logic        btn;
        logic [63:0] now;
    } request_t;

    typedef struct packed {
        logic        ev_valid;
        logic [1:0]  ev_kind;
        logic [31:0] ev_pos;
        logic [31:0] pos;
        logic        pressed;
        logic [3:0]  partial;
        logic [3:0]  pending;
    } unit_status_t;

    typedef struct {
        request_t     rq;
        bit           typed;
        unit_status_t want;
    } stim_row_t;

    typedef struct {
        logic [3:0]  detent;
        logic [19:0] debounce;
        logic [23:0] long_press;
        int unsigned step_max;
        int          pop_pct;
        logic [63:0] t0;
    } phase_t;

    localparam unit_status_t IDLE_STATUS  = '0;
    localparam unit_status_t RESYNC_HELD  = '{pressed: 1'b1, default: '0};

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    renc_req_if req_ch ();
    renc_evt_if evt_ch ();

    rotary_encoder_button_event_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .evt       (evt_ch)
    );

    // Predicted state of the unit.
    logic [3:0]  cfg_detent;
    logic [19:0] cfg_debounce;
    logic [23:0] cfg_long_press;
    logic [1:0]  enc_last_ab;
    int          enc_count;
    logic [31:0] enc_position;
    logic        btn_stable;
    logic        btn_candidate;
    logic        btn_long_done;
    logic [63:0] btn_candidate_t;
    logic [63:0] btn_press_t;
    logic [1:0]  ev_kind_mem [16];
    logic [31:0] ev_pos_mem [16];
    logic [3:0]  ev_rd;
    logic [3:0]  ev_wr;

    unit_status_t awaited_status [$];
    int           errors;
    bit           steady;

    // Directed requests: decoder steps both ways, illegal jump, button
    // debounce, long and short press, bounce, resync, time wrap.
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{'{REQ_POP,       1'b0, 1'b0, 1'b1, 64'd0},      1'b1, IDLE_STATUS},
        '{'{REQ_UPDATE,    1'b1, 1'b0, 1'b1, 64'd0},      1'b0, IDLE_STATUS},
        '{'{REQ_UPDATE,    1'b1, 1'b1, 1'b1, 64'd1},      1'b0, IDLE_STATUS},
        '{'{REQ_UPDATE,    1'b0, 1'b1, 1'b1, 64'd2},      1'b0, IDLE_STATUS},
        '{'{REQ_UPDATE,    1'b0, 1'b0, 1'b1, 64'd3},      1'b0, IDLE_STATUS},
        '{'{REQ_UPDATE,    1'b1, 1'b1, 1'b1, 64'd4},      1'b0, IDLE_STATUS},
        '{'{REQ_UPDATE,    1'b1, 1'b0, 1'b1, 64'd5},      1'b0, IDLE_STATUS},
        '{'{REQ_RESET_POS, 1'b0, 1'b0, 1'b1, 64'd6},      1'b0, IDLE_STATUS},
        '{'{REQ_POP,       1'b1, 1'b1, 1'b0, 64'd7},      1'b0, IDLE_STATUS},
        '{'{REQ_UPDATE,    1'b1, 1'b0, 1'b0, 64'd100},    1'b0, IDLE_STATUS},
        '{'{REQ_UPDATE,    1'b1, 1'b0, 1'b0, 64'd20100},  1'b0, IDLE_STATUS},
        '{'{REQ_UPDATE,    1'b1, 1'b0, 1'b0, 64'd520100}, 1'b0, IDLE_STATUS},
        '{'{REQ_UPDATE,    1'b1, 1'b0, 1'b1, 64'd520200}, 1'b0, IDLE_STATUS},
        '{'{REQ_UPDATE,    1'b1, 1'b0, 1'b1, 64'd540200}, 1'b0, IDLE_STATUS},
        '{'{REQ_UPDATE,    1'b1, 1'b0, 1'b0, 64'd600000}, 1'b0, IDLE_STATUS},
        '{'{REQ_UPDATE,    1'b1, 1'b0, 1'b0, 64'd620000}, 1'b0, IDLE_STATUS},
        '{'{REQ_UPDATE,    1'b1, 1'b0, 1'b1, 64'd620001}, 1'b0, IDLE_STATUS},
        '{'{REQ_UPDATE,    1'b1, 1'b0, 1'b1, 64'd640001}, 1'b0, IDLE_STATUS},
        '{'{REQ_UPDATE,    1'b1, 1'b0, 1'b0, 64'd700000}, 1'b0, IDLE_STATUS},
        '{'{REQ_UPDATE,    1'b1, 1'b0, 1'b1, 64'd700010}, 1'b0, IDLE_STATUS},
        '{'{REQ_POP,       1'b0, 1'b1, 1'b1, 64'd0},      1'b0, IDLE_STATUS},
        '{'{REQ_RESYNC,    1'b1, 1'b1, 1'b0, '1},         1'b1, RESYNC_HELD},
        '{'{REQ_UPDATE,    1'b1, 1'b1, 1'b0, 64'd10},     1'b0, IDLE_STATUS},
        '{'{REQ_RESYNC,    1'b0, 1'b0, 1'b1, 64'd0},      1'b1, IDLE_STATUS},
        '{'{REQ_UPDATE,    1'b0, 1'b1, 1'b1, 64'd1},      1'b0, IDLE_STATUS},
        '{'{REQ_UPDATE,    1'b1, 1'b1, 1'b1, 64'd2},      1'b0, IDLE_STATUS},
        '{'{REQ_UPDATE,    1'b1, 1'b0, 1'b1, 64'd3},      1'b0, IDLE_STATUS}
    };

    // Register settings of the random phases, extremes among them.
    phase_t phases [N_PHASES] = '{
        '{4'd4,  20'd20000, 24'd500000, 25000,   20, 64'd1000},
        '{4'd0,  20'd0,     24'd0,      3,       25, 64'd0},
        '{4'd15, 20'hFFFFF, 24'hFFFFFF, 2097152, 15, 64'h0000_0123_4567_89AB},
        '{4'd8,  20'd5,     24'd60,     10,      3,  64'h8000_0000_0000_0000},
        '{4'd1,  20'd3,     24'hFFFFFF, 8,       30, 64'd77},
        '{4'd2,  20'd10,    24'd40,     6,       10, 64'hFFFF_FFFF_FFFF_FF00}
    };

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Random idle length: mostly none, sometimes short, now and then long.
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Position of an A/B pair along the clockwise Gray order.
    function automatic int quad_rank(logic [1:0] ab);
        case (ab)
            2'b00:   return 0;
            2'b10:   return 1;
            2'b11:   return 2;
            default: return 3;
        endcase
    endfunction

    task automatic reset_model();
        cfg_detent      = DETENT_AT_RESET;
        cfg_debounce    = DEBOUNCE_AT_RESET;
        cfg_long_press  = LONG_PRESS_AT_RESET;
        enc_last_ab     = 2'b00;
        enc_count       = 0;
        enc_position    = '0;
        btn_stable      = 1'b0;
        btn_candidate   = 1'b0;
        btn_long_done   = 1'b0;
        btn_candidate_t = '0;
        btn_press_t     = '0;
        ev_rd           = '0;
        ev_wr           = '0;
    endtask

    // Queue an event with the current position; dropped when the queue is full.
    task automatic enqueue_evt(input logic [1:0] kind);
        if (ev_wr + 4'd1 == ev_rd)
            return;
        ev_kind_mem[ev_wr] = kind;
        ev_pos_mem[ev_wr]  = enc_position;
        ev_wr              = ev_wr + 4'd1;
    endtask

    // One Gray step forward counts +1, one back counts -1, a double jump 0.
    task automatic turn_encoder(input logic [1:0] ab);
        int lim;
        int diff;
        lim = (cfg_detent == 0) ? 1 : (cfg_detent > DETENT_CEILING) ? DETENT_CEILING
                                                                    : int'(cfg_detent);
        if (ab == enc_last_ab)
            return;
        diff = (quad_rank(ab) - quad_rank(enc_last_ab)) & 3;
        if (diff == 1)
            enc_count++;
        else if (diff == 3)
            enc_count--;
        enc_last_ab = ab;
        if (enc_count >= lim)
        begin
            enc_count    = 0;
            enc_position = enc_position + 32'd1;
            enqueue_evt(EV_CW);
        end
        else if (enc_count <= -lim)
        begin
            enc_count    = 0;
            enc_position = enc_position - 32'd1;
            enqueue_evt(EV_CCW);
        end
    endtask

    // Debounce the raw level, then decide short and long presses.
    task automatic sample_button(input logic level_down, input logic [63:0] now);
        if (level_down != btn_candidate)
        begin
            btn_candidate   = level_down;
            btn_candidate_t = now;
        end
        if (btn_candidate != btn_stable && now - btn_candidate_t >= {44'd0, cfg_debounce})
        begin
            btn_stable = btn_candidate;
            if (btn_stable)
            begin
                btn_press_t   = now;
                btn_long_done = 1'b0;
            end
            else if (!btn_long_done)
            begin
                enqueue_evt(EV_SHORT_PRESS);
            end
        end
        if (btn_stable && !btn_long_done && now - btn_press_t >= {40'd0, cfg_long_press})
        begin
            btn_long_done = 1'b1;
            enqueue_evt(EV_LONG_PRESS);
        end
    endtask

    // Apply one request to the predicted state and form the status it returns.
    task automatic apply_request(input request_t rq, output unit_status_t st);
        logic [1:0] ab;
        logic       level_down;
        ab         = {rq.a, rq.b};
        level_down = ~rq.btn;
        st         = '0;
        case (rq.op)
            REQ_RESYNC:
            begin
                ev_rd           = '0;
                ev_wr           = '0;
                enc_position    = '0;
                enc_count       = 0;
                enc_last_ab     = ab;
                btn_stable      = level_down;
                btn_candidate   = level_down;
                btn_candidate_t = rq.now;
                btn_press_t     = rq.now;
                btn_long_done   = 1'b0;
            end
            REQ_UPDATE:
            begin
                turn_encoder(ab);
                sample_button(level_down, rq.now);
            end
            REQ_POP:
            begin
                if (ev_rd != ev_wr)
                begin
                    st.ev_valid = 1'b1;
                    st.ev_kind  = ev_kind_mem[ev_rd];
                    st.ev_pos   = ev_pos_mem[ev_rd];
                    ev_rd       = ev_rd + 4'd1;
                end
            end
            default:
            begin
                enc_position = '0;
                enc_count    = 0;
            end
        endcase
        st.pos     = enc_position;
        st.pressed = btn_stable;
        st.partial = enc_count[3:0];
        st.pending = ev_wr - ev_rd;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [23:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_DETENT_COUNTS:   cfg_detent     = data[3:0];
            CFG_DEBOUNCE_TIME:   cfg_debounce   = data[19:0];
            CFG_LONG_PRESS_TIME: cfg_long_press = data;
            default:             ;
        endcase
    endtask

    // Drive one request after a random gap; predict it once it transfers.
    task automatic send_request(input request_t rq, input bit typed,
                                input unit_status_t typed_st);
        int           gap;
        unit_status_t st;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= rq.op;
        req_ch.pin_a        <= rq.a;
        req_ch.pin_b        <= rq.b;
        req_ch.button_level <= rq.btn;
        req_ch.now_us       <= rq.now;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        apply_request(rq, st);
        awaited_status.push_back(typed ? typed_st : st);
    endtask

    // Drop valid and let every outstanding result drain.
    task automatic wait_idle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (awaited_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly well-formed rotation and press sequences, with some noise.
    task automatic run_phase(input phase_t ph, input int items);
        logic [63:0] now;
        int          q;
        int          dir;
        int          dir_left;
        logic        btn;
        int          hold;
        int          r;
        request_t    rq;
        now      = ph.t0;
        q        = 0;
        dir      = 1;
        dir_left = 0;
        btn      = 1'b1;
        hold     = 0;
        rq       = '{REQ_RESYNC, 1'b0, 1'b0, 1'b1, now};
        send_request(rq, 1'b0, IDLE_STATUS);
        for (int i = 0; i < items; i++)
        begin
            r      = $urandom_range(0, 99);
            rq.a   = 1'($urandom_range(0, 1));
            rq.b   = 1'($urandom_range(0, 1));
            rq.btn = 1'($urandom_range(0, 1));
            rq.now = now;
            if (r < 5)
            begin
                rq.op  = req_t'($urandom_range(0, 3));
                rq.now = {$urandom, $urandom};
            end
            else if (r < 5 + ph.pop_pct)
            begin
                rq.op = REQ_POP;
            end
            else if (r < 8 + ph.pop_pct)
            begin
                rq.op = REQ_RESET_POS;
            end
            else if (r < 10 + ph.pop_pct)
            begin
                rq.op          = REQ_RESYNC;
                {rq.a, rq.b}   = QUAD_ORDER[q];
                rq.btn         = btn;
            end
            else
            begin
                rq.op  = REQ_UPDATE;
                now    = now + 64'($urandom_range(0, ph.step_max));
                rq.now = now;
                if (dir_left == 0)
                begin
                    dir      = $urandom_range(0, 1) ? 1 : -1;
                    dir_left = $urandom_range(1, 24);
                end
                dir_left--;
                r = $urandom_range(0, 99);
                if (r < 5)
                    q = q + 2;
                else if (r < 65)
                    q = q + dir;
                q            = q & 3;
                {rq.a, rq.b} = QUAD_ORDER[q];
                if (hold == 0)
                begin
                    btn  = ~btn;
                    hold = ($urandom_range(0, 9) < 2) ? $urandom_range(1, 2)
                                                      : $urandom_range(4, 40);
                end
                hold--;
                rq.btn = btn;
            end
            send_request(rq, 1'b0, IDLE_STATUS);
        end
    endtask

    // Result channel back-pressure.
    initial
    begin : sink_pacing
        int n;
        evt_ch.ready = 1'b0;
        forever
        begin
            n = pick_gap();
            repeat (n)
            begin
                @(negedge clk);
                evt_ch.ready <= 1'b0;
            end
            n = $urandom_range(1, 8);
            repeat (n)
            begin
                @(negedge clk);
                evt_ch.ready <= 1'b1;
            end
        end
    end

    // Compare every result transfer with the oldest predicted status.
    always @(posedge clk)
    begin : result_check
        unit_status_t want;
        if (evt_ch.valid === 1'b1 && evt_ch.ready === 1'b1)
        begin
            if (awaited_status.size() == 0)
            begin
                report_mismatch("unexpected result, position", evt_ch.position, '0);
            end
            else
            begin
                want = awaited_status.pop_front();
                if (evt_ch.event_valid !== want.ev_valid)
                    report_mismatch("event_valid", evt_ch.event_valid, want.ev_valid);
                if (evt_ch.event_kind !== want.ev_kind)
                    report_mismatch("event_kind", evt_ch.event_kind, want.ev_kind);
                if (evt_ch.event_position !== want.ev_pos)
                    report_mismatch("event_position", evt_ch.event_position, want.ev_pos);
                if (evt_ch.position !== want.pos)
                    report_mismatch("position", evt_ch.position, want.pos);
                if (evt_ch.button_pressed !== want.pressed)
                    report_mismatch("button_pressed", evt_ch.button_pressed, want.pressed);
                if (evt_ch.partial_count !== want.partial)
                    report_mismatch("partial_count", evt_ch.partial_count, want.partial);
                if (evt_ch.pending_events !== want.pending)
                    report_mismatch("pending_events", evt_ch.pending_events, want.pending);
            end
        end
    end

    // End the run when no transfer happens for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (evt_ch.valid === 1'b1 && evt_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Reset, directed table, then random phases under several settings.
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_DETENT_COUNTS;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_RESYNC;
        req_ch.pin_a        = 1'b0;
        req_ch.pin_b        = 1'b0;
        req_ch.button_level = 1'b1;
        req_ch.now_us       = '0;
        errors              = 0;
        steady              = 1'b0;
        reset_model();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);

        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_idle();
            write_register(CFG_DETENT_COUNTS, {20'd0, phases[p].detent});
            write_register(CFG_DEBOUNCE_TIME, {4'd0, phases[p].debounce});
            write_register(CFG_LONG_PRESS_TIME, phases[p].long_press);
            if (p == 4)
                write_register(CFG_UNUSED_INDEX, 24'($urandom));
            steady = (p % 3 == 1);
            run_phase(phases[p], PHASE_ITEMS);
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (errors == 0 && awaited_status.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== rotary_encoder_button_event_unit.f =====
rtl/core/renc_pkg.sv
rtl/core/renc_if.sv
rtl/core/renc_ram.sv
rtl/core/renc_quad.sv
rtl/core/renc_button.sv
rtl/core/renc_evq.sv
rtl/core/rotary_encoder_button_event_unit.sv
verif/tb_rotary_encoder_button_event_unit.sv
